// ----- rtl/pts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the thread scheduler
// Sizes, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int THREAD_SLOTS = 8;
    localparam int EVENT_SLOTS  = 4;
    localparam int SLOT_W       = $clog2(THREAD_SLOTS);
    localparam int EVT_W        = $clog2(EVENT_SLOTS);
    localparam int LIVE_W       = $clog2(THREAD_SLOTS + 1);
    localparam int ECNT_W       = $clog2(EVENT_SLOTS + 1);
    localparam int ID_SHIFT     = 16;
    localparam logic [7:0] PRIO_NONE = 8'd255;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_EVENT    = 3'd2;
    localparam logic [2:0] OP_SLEEP    = 3'd3;
    localparam logic [2:0] OP_KILL     = 3'd4;
    localparam logic [2:0] OP_SCHEDULE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_LAST    = 2'd2;
    localparam logic [1:0] ST_NO_SUCH = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVENTS,
        S_SLOTS,
        S_RESULT
    } seq_state_t;

endpackage
`default_nettype wire

// ----- rtl/priority_thread_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// priority_thread_scheduler: fixed priority preemptive thread scheduler
// Thread slot table and periodic event table walked one entry per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | mode, prio_level, sleep_ticks,
//          |           |                        | event_interval, target_id
//  out     | output    | out_valid / out_stall  | status_code, running_slot,
//          |           |                        | running_id, switch_request,
//          |           |                        | fired_events, new_id
//
// A tick walks the event table, when it holds entries, and then the slot
// table; add, kill and schedule walk the slot table, one slot per cycle;
// the rest, and a kill with a single live thread, go straight to the result.
// The result sits in an output register; a new item is held off while it
// waits and can be taken in the cycle in which the result transfers.
// Reset clears all control state, the thread table and the counters.
module priority_thread_scheduler
    import pts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  prio_level,
    input  wire logic [31:0] sleep_ticks,
    input  wire logic [31:0] event_interval,
    input  wire logic [31:0] target_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status_code,
    output logic [2:0]       running_slot,
    output logic [31:0]      running_id,
    output logic             switch_request,
    output logic [3:0]       fired_events,
    output logic [31:0]      new_id
);

    seq_state_t state_reg, state_next;

    logic [2:0]  op_reg;
    logic [7:0]  prio_reg;
    logic [31:0] sleep_reg;
    logic [31:0] intv_reg;
    logic [31:0] target_reg;

    logic [31:0] tick_reg;
    logic [THREAD_SLOTS-1:0] live_reg;
    logic [THREAD_SLOTS-1:0] sleeping_reg;
    logic [7:0]  prio_tab [THREAD_SLOTS];
    logic [31:0] wake_tab [THREAD_SLOTS];
    logic [31:0] ident_tab [THREAD_SLOTS];
    logic [15:0] id_cnt_reg;
    logic [LIVE_W-1:0] live_cnt_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [31:0] ev_intv [EVENT_SLOTS];
    logic [31:0] ev_due [EVENT_SLOTS];
    logic [ECNT_W-1:0] ev_cnt_reg;

    // walk state
    logic [SLOT_W:0]   idx_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] hit_reg;
    logic [7:0]        best_reg;
    logic [3:0]        fired_reg;

    logic [SLOT_W-1:0] slot_ix;
    logic [EVT_W-1:0]  ev_ix;
    logic              take;
    logic              slot_last;
    logic              ev_last;
    logic              has_events;
    logic [31:0]       wake_sum;
    logic              ready_now;

    assign take      = in_valid && !in_stall;
    assign slot_ix   = idx_reg[SLOT_W-1:0];
    assign ev_ix     = idx_reg[EVT_W-1:0];
    assign slot_last = (idx_reg == (SLOT_W+1)'(THREAD_SLOTS - 1));
    assign ev_last   = ({{(ECNT_W){1'b0}}, idx_reg} + 1'b1) >= (ECNT_W + SLOT_W + 1)'(ev_cnt_reg)
                       || (idx_reg == (SLOT_W+1)'(EVENT_SLOTS - 1));
    assign has_events = (ev_cnt_reg != '0);
    assign in_stall  = (state_reg != S_IDLE) || (out_valid && out_stall);
    assign wake_sum  = sleep_reg + tick_reg;
    assign ready_now = live_reg[pos_reg] && !sleeping_reg[pos_reg]
                       && (prio_tab[pos_reg] < best_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (mode == OP_TICK)
                        state_next = has_events ? S_EVENTS : S_SLOTS;
                    else if (mode == OP_ADD || mode == OP_SCHEDULE
                             || (mode == OP_KILL && live_cnt_reg != LIVE_W'(1)))
                        state_next = S_SLOTS;
                    else
                        state_next = S_RESULT;
                end
            end
            S_EVENTS: if (ev_last) state_next = S_SLOTS;
            S_SLOTS:  if (slot_last) state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath and tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= '0;
            prio_reg     <= '0;
            sleep_reg    <= '0;
            intv_reg     <= '0;
            target_reg   <= '0;
            tick_reg     <= '0;
            live_reg     <= '0;
            sleeping_reg <= '0;
            id_cnt_reg   <= '0;
            live_cnt_reg <= '0;
            cur_reg      <= '0;
            ev_cnt_reg   <= '0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            found_reg    <= 1'b0;
            hit_reg      <= '0;
            best_reg     <= PRIO_NONE;
            fired_reg    <= '0;
            out_valid    <= 1'b0;
            status_code  <= ST_OK;
            running_slot <= '0;
            running_id   <= '0;
            switch_request <= 1'b0;
            fired_events <= '0;
            new_id       <= '0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                prio_tab[i]  <= PRIO_NONE;
                wake_tab[i]  <= '0;
                ident_tab[i] <= '0;
            end
            for (int i = 0; i < EVENT_SLOTS; i++)
            begin
                ev_intv[i] <= '0;
                ev_due[i]  <= '0;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        op_reg     <= mode;
                        prio_reg   <= prio_level;
                        sleep_reg  <= sleep_ticks;
                        intv_reg   <= event_interval;
                        target_reg <= target_id;
                        idx_reg    <= '0;
                        pos_reg    <= cur_reg;
                        found_reg  <= 1'b0;
                        best_reg   <= PRIO_NONE;
                        fired_reg  <= '0;
                        if (mode == OP_TICK)
                            tick_reg <= tick_reg + 32'd1;
                    end
                end
                S_EVENTS:
                begin
                    if (ev_due[ev_ix] == tick_reg)
                    begin
                        ev_due[ev_ix] <= ev_intv[ev_ix] + tick_reg;
                        fired_reg[ev_ix] <= 1'b1;
                    end
                    idx_reg <= ev_last ? '0 : idx_reg + 1'b1;
                end
                S_SLOTS:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    pos_reg <= pos_reg + 1'b1;
                    case (op_reg)
                        OP_TICK:
                            if (live_reg[slot_ix] && sleeping_reg[slot_ix]
                                && wake_tab[slot_ix] == tick_reg)
                                sleeping_reg[slot_ix] <= 1'b0;
                        OP_ADD:
                            if (!found_reg && !live_reg[slot_ix])
                            begin
                                found_reg <= 1'b1;
                                hit_reg   <= slot_ix;
                            end
                        OP_KILL:
                            if (!found_reg && live_reg[slot_ix]
                                && ident_tab[slot_ix] == target_reg)
                            begin
                                found_reg <= 1'b1;
                                hit_reg   <= slot_ix;
                            end
                        OP_SCHEDULE:
                            if (ready_now)
                            begin
                                best_reg  <= prio_tab[pos_reg];
                                hit_reg   <= pos_reg;
                                found_reg <= 1'b1;
                            end
                        default: ;
                    endcase
                end
                S_RESULT:
                begin
                    out_valid      <= 1'b1;
                    status_code    <= ST_OK;
                    switch_request <= 1'b0;
                    fired_events   <= '0;
                    new_id         <= '0;
                    running_slot   <= 3'(cur_reg);
                    running_id     <= live_reg[cur_reg] ? ident_tab[cur_reg] : '0;
                    case (op_reg)
                        OP_TICK:
                        begin
                            switch_request <= 1'b1;
                            fired_events   <= fired_reg;
                        end
                        OP_ADD:
                            if (!found_reg)
                                status_code <= ST_FULL;
                            else
                            begin
                                new_id <= {id_cnt_reg, 16'(hit_reg)};
                                id_cnt_reg <= id_cnt_reg + 16'd1;
                                live_reg[hit_reg]     <= 1'b1;
                                sleeping_reg[hit_reg] <= 1'b0;
                                wake_tab[hit_reg]     <= '0;
                                prio_tab[hit_reg]     <= prio_reg;
                                ident_tab[hit_reg]    <= {id_cnt_reg, 16'(hit_reg)};
                                live_cnt_reg <= live_cnt_reg + 1'b1;
                                if (hit_reg == cur_reg)
                                    running_id <= {id_cnt_reg, 16'(hit_reg)};
                            end
                        OP_EVENT:
                            if (ev_cnt_reg >= ECNT_W'(EVENT_SLOTS))
                                status_code <= ST_FULL;
                            else
                            begin
                                ev_intv[ev_cnt_reg[EVT_W-1:0]] <= intv_reg;
                                ev_due[ev_cnt_reg[EVT_W-1:0]]  <=
                                    32'(ev_cnt_reg) + 32'd1;
                                ev_cnt_reg <= ev_cnt_reg + 1'b1;
                            end
                        OP_SLEEP:
                            if (live_reg[cur_reg])
                            begin
                                wake_tab[cur_reg]     <= wake_sum;
                                sleeping_reg[cur_reg] <= 1'b1;
                                switch_request        <= 1'b1;
                            end
                        OP_KILL:
                            if (live_cnt_reg == LIVE_W'(1))
                                status_code <= ST_LAST;
                            else if (!found_reg)
                                status_code <= ST_NO_SUCH;
                            else
                            begin
                                live_reg[hit_reg]     <= 1'b0;
                                sleeping_reg[hit_reg] <= 1'b0;
                                prio_tab[hit_reg]     <= PRIO_NONE;
                                wake_tab[hit_reg]     <= '0;
                                ident_tab[hit_reg]    <= '0;
                                live_cnt_reg <= live_cnt_reg - 1'b1;
                                if (hit_reg == cur_reg)
                                begin
                                    switch_request <= 1'b1;
                                    running_id     <= '0;
                                end
                            end
                        OP_SCHEDULE:
                            if (found_reg)
                            begin
                                cur_reg      <= hit_reg;
                                running_slot <= 3'(hit_reg);
                                running_id   <= ident_tab[hit_reg];
                            end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // A result is only produced from the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_RESULT))
        else $error("result appeared outside the result state");

    // The live count always matches the live flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        LIVE_W'($countones(live_reg)) == live_cnt_reg)
        else $error("live count out of step with live flags");

    // No new transfer is taken while an item is being worked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while busy");

endmodule
`default_nettype wire
